// ===== rtl/dvd_pkg.sv =====
// ============================================================================
// dvd_pkg: shared definitions for the pipelined restoring divider
// Holds the operand width and the stage and result types that the division
// steps, the output skid stage and the top level have in common.
// ============================================================================
package dvd_pkg;

    // Width of the arithmetic. The channel fields stay at FIELD_WIDTH bits.
    // Only the low DATA_WIDTH bits of the operands are used. Results are
    // zero-extended. DATA_WIDTH may range from 8 to 64.
    localparam int DATA_WIDTH  = 64;
    localparam int FIELD_WIDTH = 64;

    // State of one word as it moves down the division pipeline.
    // qn starts as the dividend magnitude. Each step shifts one dividend bit
    // out at the top and one quotient bit in at the bottom.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] qn;
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] den;
        logic                  neg_q;
        logic                  neg_r;
        logic                  zero;
    } stage_t;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] quotient;
        logic [FIELD_WIDTH-1:0] remainder;
    } result_t;

endpackage

// ===== rtl/dvd_if.sv =====
// ============================================================================
// dvd_if: valid/ready channels of the divider
// One interface for operand words and one for result words.
// ============================================================================
interface dvd_in_if;
    logic                              valid;
    logic                              ready;
    logic                              is_signed;
    logic [dvd_pkg::FIELD_WIDTH-1:0]   dividend;
    logic [dvd_pkg::FIELD_WIDTH-1:0]   divisor;

    modport source (output valid, output is_signed, output dividend, output divisor,
                    input ready);
    modport sink   (input valid, input is_signed, input dividend, input divisor,
                    output ready);
endinterface

interface dvd_out_if;
    logic                              valid;
    logic                              ready;
    logic [dvd_pkg::FIELD_WIDTH-1:0]   quotient;
    logic [dvd_pkg::FIELD_WIDTH-1:0]   remainder;

    modport source (output valid, output quotient, output remainder, input ready);
    modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

// ===== rtl/dvd_step.sv =====
// ============================================================================
// dvd_step: one registered stage of restoring division
// Brings down one dividend bit, trial-subtracts the divisor and keeps the
// difference when it does not go negative, producing one quotient bit.
// ============================================================================
module dvd_step (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  dvd_pkg::stage_t in_stage,
    output logic            out_valid,
    output dvd_pkg::stage_t out_stage
);

    logic                        valid_reg;
    dvd_pkg::stage_t             stage_reg;
    dvd_pkg::stage_t             stage_next;
    logic [dvd_pkg::DATA_WIDTH:0] shifted;
    logic [dvd_pkg::DATA_WIDTH:0] diff;
    logic                        fits;

    always_comb
    begin
        // The partial remainder is one bit wider than the divisor so that the
        // carry out of the shift takes part in the compare.
        shifted    = {in_stage.rem, in_stage.qn[dvd_pkg::DATA_WIDTH-1]};
        diff       = shifted - {1'b0, in_stage.den};
        fits       = ~diff[dvd_pkg::DATA_WIDTH];
        stage_next = in_stage;
        stage_next.rem = fits ? diff[dvd_pkg::DATA_WIDTH-1:0]
                              : shifted[dvd_pkg::DATA_WIDTH-1:0];
        stage_next.qn  = {in_stage.qn[dvd_pkg::DATA_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== rtl/dvd_skid.sv =====
// ============================================================================
// dvd_skid: output skid register
// Catches the last pipeline word when the receiver stalls, so that the
// pipeline stall signal comes straight from a flip-flop.
// ============================================================================
module dvd_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  dvd_pkg::result_t in_data,
    output logic             advance,
    output logic             out_valid,
    output dvd_pkg::result_t out_data,
    input  logic             out_ready
);

    logic             skid_valid_reg;
    logic             skid_valid_next;
    dvd_pkg::result_t skid_data_reg;

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg && out_ready)
        begin
            skid_valid_next = 1'b0;
        end
        else if (!skid_valid_reg && in_valid && !out_ready)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign advance   = ~skid_valid_reg;
    assign out_valid = skid_valid_reg | in_valid;
    assign out_data  = skid_valid_reg ? skid_data_reg : in_data;

endmodule

// ===== rtl/divide_64bit_signed_unsigned_core.sv =====
// ============================================================================
// divide_64bit_signed_unsigned_core: pipelined signed/unsigned divider
// Restoring division, one quotient bit per pipeline stage, with sign
// handling before and after the division stages.
// ============================================================================
// Usage:
//   operands carries one word per division: is_signed, dividend and divisor.
//   results carries the quotient and remainder of that division, in order.
//   In signed mode the quotient truncates toward zero and the remainder has
//   the sign of the dividend. The most negative value divided by minus one
//   wraps to itself. A zero divisor returns zero for both results.
//   The result word shows on results after one sign stage, DATA_WIDTH division
//   stages (one per quotient bit) and one fix-up stage. A new word can be
//   accepted every cycle while the skid register is empty. When the receiver
//   stalls, the skid register takes the waiting word and operands.ready drops
//   in the next cycle, freezing the whole pipeline, so no word is lost or
//   repeated. ready comes directly from a flip-flop.
//   Reset clears all valid bits; the pipeline then takes words at once.
// ============================================================================
module divide_64bit_signed_unsigned_core (
    input  logic      clk,
    input  logic      rst_n,
    dvd_in_if.sink    operands,
    dvd_out_if.source results
);

    localparam int W = dvd_pkg::DATA_WIDTH;

    logic advance;

    // Input operand views at the working width.
    logic [W-1:0] num;
    logic [W-1:0] den;
    logic         num_neg;
    logic         den_neg;
    dvd_pkg::stage_t prep_next;

    // Pipeline stage 0 holds the operand magnitudes; stages 1..W are division.
    logic            vld [0:W];
    dvd_pkg::stage_t stg [0:W];

    logic            prep_valid_reg;
    dvd_pkg::stage_t prep_reg;

    // Fix-up stage.
    dvd_pkg::stage_t  last;
    logic [W-1:0]     q_fix;
    logic [W-1:0]     r_fix;
    dvd_pkg::result_t post_next;
    logic             post_valid_reg;
    dvd_pkg::result_t post_reg;
    dvd_pkg::result_t out_data;

    // ------------------------------------------------------------------
    // Sign stage: take magnitudes and note which results need negating.
    // ------------------------------------------------------------------
    always_comb
    begin
        num     = W'(operands.dividend);
        den     = W'(operands.divisor);
        num_neg = operands.is_signed & num[W-1];
        den_neg = operands.is_signed & den[W-1];
        prep_next.qn    = num_neg ? (~num + W'(1)) : num;
        prep_next.den   = den_neg ? (~den + W'(1)) : den;
        prep_next.rem   = '0;
        prep_next.neg_q = num_neg ^ den_neg;
        prep_next.neg_r = num_neg;
        prep_next.zero  = (den == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            prep_valid_reg <= operands.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prep_reg <= prep_next;
        end
    end

    assign operands.ready = advance;
    assign vld[0] = prep_valid_reg;
    assign stg[0] = prep_reg;

    // ------------------------------------------------------------------
    // Division stages: one quotient bit each, most significant first.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < W; i++)
    begin : g_step
        dvd_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (vld[i]),
            .in_stage  (stg[i]),
            .out_valid (vld[i+1]),
            .out_stage (stg[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Fix-up stage: restore signs and force zero results for a zero divisor.
    // ------------------------------------------------------------------
    always_comb
    begin
        last  = stg[W];
        q_fix = last.neg_q ? (~last.qn + W'(1)) : last.qn;
        r_fix = last.neg_r ? (~last.rem + W'(1)) : last.rem;
        if (last.zero)
        begin
            q_fix = '0;
            r_fix = '0;
        end
        post_next.quotient  = dvd_pkg::FIELD_WIDTH'(q_fix);
        post_next.remainder = dvd_pkg::FIELD_WIDTH'(r_fix);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            post_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            post_valid_reg <= vld[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            post_reg <= post_next;
        end
    end

    // ------------------------------------------------------------------
    // Output skid register; its fill state is the pipeline stall.
    // ------------------------------------------------------------------
    dvd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (post_valid_reg),
        .in_data   (post_reg),
        .advance   (advance),
        .out_valid (results.valid),
        .out_data  (out_data),
        .out_ready (results.ready)
    );

    assign results.quotient  = out_data.quotient;
    assign results.remainder = out_data.remainder;

endmodule

// ===== rtl/dvd_checker.sv =====
// ============================================================================
// dvd_checker: port-level checks for the divider
// Watches the handshakes on the top level and checks the stall behavior.
// ============================================================================
module dvd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [dvd_pkg::FIELD_WIDTH-1:0] quotient,
    input logic [dvd_pkg::FIELD_WIDTH-1:0] remainder
);

    // A stalled result word stays and does not change.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quotient) && $stable(remainder))
        else $error("result word changed while stalled");

    // The operand side only stops after the receiver refused a word.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("operand ready dropped without an output stall");

    // Once the waiting word is taken, the operand side reopens at once.
    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready && out_valid && out_ready |=> in_ready)
        else $error("operand ready did not return after the stall cleared");

endmodule

bind divide_64bit_signed_unsigned_core dvd_checker u_dvd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (operands.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .quotient  (results.quotient),
    .remainder (results.remainder)
);

// ===== sim/tb.sv =====
// ============================================================================
// tb: self-checking bench for the pipelined signed/unsigned divider
// Drives operand words through a bursty valid/ready source and takes result
// words through a sink that stalls on changing patterns. Every accepted
// operand word is divided by a bit-serial restoring predictor in the bench,
// and each result word is checked in order against that prediction.
// ============================================================================
module tb;

    // The arithmetic width and the channel field width come from the package,
    // so the bench follows the block if DATA_WIDTH is changed there.
    localparam int DW = dvd_pkg::DATA_WIDTH;
    localparam int FW = dvd_pkg::FIELD_WIDTH;

    // Handy operand values at the arithmetic width.
    localparam logic [FW-1:0] DMASK = {FW{1'b1}} >> (FW - DW);
    localparam logic [FW-1:0] SMIN  = {{(FW-1){1'b0}}, 1'b1} << (DW - 1);
    localparam logic [FW-1:0] SMAX  = DMASK >> 1;

    // The longest quiet stretch of a correct run is a sender gap or a drain
    // pause plus the pipeline latency plus a few receiver stalls. The limit
    // is set well above that.
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_WAIT  = 2 * (DW + 1);
    localparam int RANDOM_WORDS = 1800;

    // One operand word as the bench queues it. drain_first makes the sender
    // hold this word back until every earlier result word has come out.
    typedef struct {
        logic          is_signed;
        logic [FW-1:0] dividend;
        logic [FW-1:0] divisor;
        bit            drain_first;
    } division_t;

    // A predicted result word, with the operands kept for the error report.
    typedef struct {
        division_t        operand;
        dvd_pkg::result_t want;
    } awaited_t;

    logic clk = 1'b0;
    logic rst_n;

    dvd_in_if  operands ();
    dvd_out_if results ();

    divide_64bit_signed_unsigned_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands),
        .results  (results)
    );

    always #5 clk = ~clk;

    division_t division_queue[$];   // operand words not yet offered
    awaited_t  awaited_results[$];  // predictions for accepted words, oldest first
    int        results_seen;        // result words taken so far
    int        mismatches;

    // ------------------------------------------------------------------------
    // Predictor. The magnitudes are divided one quotient bit at a time from
    // the top down. The carry out of the shifted partial remainder forces a
    // subtract, which matters once the divisor magnitude has its top bit set.
    // The signs are then put back: the quotient is negated when the operand
    // signs differ and the remainder follows the dividend. A zero divisor
    // leaves both results at zero, and the most negative value over minus one
    // wraps back to itself because the negation is done at DW bits.
    // ------------------------------------------------------------------------
    function automatic dvd_pkg::result_t restoring_divide(division_t w);
        logic [DW-1:0]    num;
        logic [DW-1:0]    den;
        logic [DW-1:0]    quo;
        logic [DW-1:0]    rem;
        logic             num_neg;
        logic             den_neg;
        logic             carry;
        logic             fit;
        int               step;
        dvd_pkg::result_t res;
        num     = w.dividend[DW-1:0];
        den     = w.divisor[DW-1:0];
        num_neg = w.is_signed & num[DW-1];
        den_neg = w.is_signed & den[DW-1];
        if (num_neg)
            num = -num;
        if (den_neg)
            den = -den;
        quo = '0;
        rem = '0;
        if (den != '0)
        begin
            // The dividend is shifted out at the top, the quotient in at the
            // bottom, one bit per step.
            for (step = 0; step < DW; step++)
            begin
                carry = rem[DW-1];
                rem   = {rem[DW-2:0], num[DW-1]};
                num   = num << 1;
                fit   = carry || (rem >= den);
                if (fit)
                    rem = rem - den;
                quo = {quo[DW-2:0], fit};
            end
        end
        if (num_neg != den_neg)
            quo = -quo;
        if (num_neg)
            rem = -rem;
        res.quotient  = FW'(quo);
        res.remainder = FW'(rem);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Operand generation.
    // ------------------------------------------------------------------------

    // Two's complement negation kept to the arithmetic width.
    function automatic logic [FW-1:0] negate_word(logic [FW-1:0] v);
        return (~v + 1'b1) & DMASK;
    endfunction

    function automatic logic [FW-1:0] full_word();
        logic [FW-1:0] raw;
        raw = {$urandom(), $urandom()};
        return raw & DMASK;
    endfunction

    // Magnitudes spread over every length, so that quotients of every size
    // and divisors of every size show up, not only huge random ones.
    function automatic logic [FW-1:0] spread_word();
        return full_word() >> $urandom_range(0, DW - 1);
    endfunction

    function automatic logic [FW-1:0] corner_word();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return 1;
            2:       return DMASK;
            3:       return SMIN;
            4:       return SMAX;
            5:       return SMIN + 1;
            default: return 2;
        endcase
    endfunction

    function automatic division_t random_division();
        division_t w;
        w.is_signed   = 1'($urandom_range(0, 1));
        w.drain_first = 1'b0;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                w.dividend = full_word();
                w.divisor  = full_word();
            end
            2, 3:
            begin
                w.dividend = spread_word();
                w.divisor  = spread_word();
            end
            4:
            begin
                w.dividend = full_word();
                w.divisor  = FW'($urandom_range(1, 255));
            end
            5:
            begin
                // Exact multiples, so the remainder often comes out zero.
                w.divisor  = spread_word();
                w.dividend = (w.divisor * FW'($urandom_range(1, 1000))) & DMASK;
            end
            6:
            begin
                w.dividend = corner_word();
                w.divisor  = spread_word();
            end
            7:
            begin
                w.dividend = full_word();
                w.divisor  = corner_word();
            end
            8:
            begin
                w.dividend = corner_word();
                w.divisor  = corner_word();
            end
            default:
            begin
                w.dividend = full_word();
                w.divisor  = $urandom_range(0, 1) ? '0 : w.dividend;
            end
        endcase
        // In signed mode every sign combination should turn up often.
        if (w.is_signed && $urandom_range(0, 1))
            w.dividend = negate_word(w.dividend);
        if (w.is_signed && $urandom_range(0, 1))
            w.divisor = negate_word(w.divisor);
        return w;
    endfunction

    function automatic division_t make_division(logic sgn, logic [FW-1:0] num,
                                                logic [FW-1:0] den);
        division_t w;
        w.is_signed   = sgn;
        w.dividend    = num;
        w.divisor     = den;
        w.drain_first = 1'b0;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. It offers words in bursts of random length with random gaps in
    // between. A word that is offered stays on the channel untouched until it
    // is taken. The sender keeps its own count of words taken, and a word
    // marked drain_first waits until results_seen has caught up with it.
    // Since results_seen is updated with a nonblocking assignment, the sender
    // always sees last cycle's count, which can only lengthen that pause.
    // ------------------------------------------------------------------------
    int words_sent;
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin : sender
        division_t next_word;
        if (!rst_n)
        begin
            operands.valid     <= 1'b0;
            operands.is_signed <= 1'b0;
            operands.dividend  <= '0;
            operands.divisor   <= '0;
            words_sent = 0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (operands.valid && operands.ready)
                words_sent = words_sent + 1;
            if (!operands.valid || operands.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    operands.valid <= 1'b0;
                end
                else if (division_queue.size() == 0 ||
                         (division_queue[0].drain_first && words_sent != results_seen))
                begin
                    operands.valid <= 1'b0;
                end
                else
                begin
                    next_word = division_queue.pop_front();
                    operands.valid     <= 1'b1;
                    operands.is_signed <= next_word.is_signed;
                    operands.dividend  <= next_word.dividend;
                    operands.divisor   <= next_word.divisor;
                    // At the end of a burst pick the gap that follows it.
                    // Gaps of zero give back-to-back stretches, and the long
                    // ones let the pipeline run partly or wholly empty.
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            8:       gap_left = $urandom_range(10, 90);
                            9:       gap_left = 0;
                            default: gap_left = $urandom_range(1, 6);
                        endcase
                    end
                    else
                    begin
                        burst_left = burst_left - 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. ready follows a 16-bit pattern, stepped through in turn, that is
    // replaced at random intervals: always ready, a single stall slot, random, or
    // mostly stalled. Bit 0 is always set, so every stall ends when the phase wraps.
    // ------------------------------------------------------------------------
    logic [15:0] stall_pattern;
    logic [3:0]  stall_phase;
    int          pattern_age;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
            stall_pattern = '1;
            stall_phase   = '0;
            pattern_age   = 0;
        end
        else
        begin
            if (pattern_age == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = '1;
                    1:       stall_pattern = ~(16'h1 << $urandom_range(1, 15));
                    2:       stall_pattern = 16'($urandom());
                    default: stall_pattern = 16'($urandom() & $urandom());
                endcase
                stall_pattern[0] = 1'b1;
                pattern_age = $urandom_range(50, 400);
            end
            else
            begin
                pattern_age = pattern_age - 1;
            end
            results.ready <= stall_pattern[stall_phase];
            stall_phase = stall_phase + 4'd1;
        end
    end

    // ------------------------------------------------------------------------
    // Checker. Both handshakes are sampled at the same edge, the operand side
    // first, so a prediction is always queued before its result could be
    // looked for. Each result word is compared with the oldest prediction,
    // quotient and remainder on their own.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        division_t taken;
        awaited_t  entry;
        if (!rst_n)
        begin
            results_seen <= 0;
        end
        else
        begin
            if (operands.valid && operands.ready)
            begin
                taken.is_signed   = operands.is_signed;
                taken.dividend    = operands.dividend;
                taken.divisor     = operands.divisor;
                taken.drain_first = 1'b0;
                entry.operand     = taken;
                entry.want        = restoring_divide(taken);
                awaited_results.push_back(entry);
            end
            if (results.valid && results.ready)
            begin
                results_seen <= results_seen + 1;
                if (awaited_results.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    $display("%0t: result word with no division outstanding: q %h r %h",
                             $time, results.quotient, results.remainder);
                end
                else
                begin
                    entry = awaited_results.pop_front();
                    if (results.quotient !== entry.want.quotient)
                    begin
                        mismatches = mismatches + 1;
                        $display("%0t: quotient of %h / %h (signed %0b): expected %h, got %h",
                                 $time, entry.operand.dividend, entry.operand.divisor,
                                 entry.operand.is_signed, entry.want.quotient,
                                 results.quotient);
                    end
                    if (results.remainder !== entry.want.remainder)
                    begin
                        mismatches = mismatches + 1;
                        $display("%0t: remainder of %h / %h (signed %0b): expected %h, got %h",
                                 $time, entry.operand.dividend, entry.operand.divisor,
                                 entry.operand.is_signed, entry.want.remainder,
                                 results.remainder);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. Any cycle in which neither channel moves a word counts toward
    // the limit; a hung pipeline or a lost word ends the run here.
    // ------------------------------------------------------------------------
    int idle_cycles;

    always @(posedge clk)
    begin
        if (!rst_n || (operands.valid && operands.ready) ||
            (results.valid && results.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        division_t w;
        int        n;
        // Reset is asserted from time zero; the sender and the receiver put
        // the channel signals at rest while it is held.
        rst_n = 1'b0;

        // Directed words: zero divisors in both modes, the unsigned extremes,
        // the most negative value over minus one, and every sign combination
        // with truncation toward zero.
        division_queue.push_back(make_division(1'b0, '0, '0));
        division_queue.push_back(make_division(1'b0, DMASK, '0));
        division_queue.push_back(make_division(1'b1, SMIN, '0));
        division_queue.push_back(make_division(1'b1, DMASK, '0));
        division_queue.push_back(make_division(1'b0, DMASK, 1));
        division_queue.push_back(make_division(1'b0, DMASK, DMASK));
        division_queue.push_back(make_division(1'b0, 1, DMASK));
        division_queue.push_back(make_division(1'b0, '0, DMASK));
        division_queue.push_back(make_division(1'b0, DMASK, 2));
        division_queue.push_back(make_division(1'b0, SMIN, DMASK));
        division_queue.push_back(make_division(1'b0, DMASK, SMIN));
        division_queue.push_back(make_division(1'b1, SMIN, DMASK));
        division_queue.push_back(make_division(1'b1, SMIN, 1));
        division_queue.push_back(make_division(1'b1, SMIN, SMIN));
        division_queue.push_back(make_division(1'b1, DMASK, SMIN));
        division_queue.push_back(make_division(1'b1, SMAX, DMASK));
        division_queue.push_back(make_division(1'b1, SMAX, SMIN));
        division_queue.push_back(make_division(1'b1, negate_word(7), 2));
        division_queue.push_back(make_division(1'b1, 7, negate_word(2)));
        division_queue.push_back(make_division(1'b1, negate_word(7), negate_word(2)));
        division_queue.push_back(make_division(1'b1, 7, 2));
        division_queue.push_back(make_division(1'b1, SMIN, 3));
        division_queue.push_back(make_division(1'b1, '0, negate_word(5)));
        division_queue.push_back(make_division(1'b0, SMAX, SMIN));

        // Random words. A few of them make the sender wait for the pipeline
        // to drain completely before they go in.
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            w = random_division();
            w.drain_first = (n % 600 == 0);
            division_queue.push_back(w);
        end

        // Reset is let go at a rising edge.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last word to be taken, then for every result word,
        // then a while longer so that a stray extra word would be caught.
        while (division_queue.size() != 0 || operands.valid)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
